// ----- design/btc_pkg.sv -----
// Shared constants, types and helpers for the block transposition cipher.
// Used by every module of the block; depends on nothing.
package btc_pkg;

  localparam int MAX_BLOCK = 16;
  localparam int IDX_W     = $clog2(MAX_BLOCK);
  localparam int CNT_W     = IDX_W + 1;
  localparam int BUF_AW    = IDX_W + 1;
  localparam int PERM_W    = MAX_BLOCK * IDX_W;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 64;

  localparam logic [7:0] PAD_BYTE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT   = 2'd2;

  localparam logic [PERM_W-1:0] PERM_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd1;

  // One closed block awaiting emission
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] held;
  } desc_t;

  // Buffer write from the front
  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  // Back status
  typedef struct packed {
    logic hold_v;
    logic flush;
  } back_st_t;

  function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] blen);
    logic [CNT_W-1:0] k;
    if (blen == '0) begin
      k = CNT_W'(1);
    end else if (blen > LEN_W'(MAX_BLOCK)) begin
      k = CNT_W'(MAX_BLOCK);
    end else begin
      k = CNT_W'(blen);
    end
    return k;
  endfunction

  function automatic logic [IDX_W-1:0] perm_entry(input logic [PERM_W-1:0] perm,
                                                  input logic [IDX_W-1:0]  j);
    return perm[j*IDX_W +: IDX_W];
  endfunction

endpackage

// ----- design/btc_front.sv -----
// Front end: counts bytes into the current block, writes them to the
// buffer bank being filled and closes blocks. Depends on btc_pkg.
module btc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [btc_pkg::CNT_W-1:0] k,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] text_byte
  input  logic                   in_tlast,   // end_of_text
  input  logic                   q_full,
  output logic                   push,
  output btc_pkg::desc_t         push_desc,
  output btc_pkg::wr_t           wr,
  output logic                   wbank
);
  import btc_pkg::*;

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             wbank_r, wbank_nxt;
  logic [CNT_W-1:0] fill_inc;
  logic             accept;
  logic             close;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign fill_inc  = fill_r + CNT_W'(1);
  assign close     = (fill_inc >= k) || in_tlast;
  assign push      = accept && close;
  assign wbank     = wbank_r;

  assign push_desc.bank = wbank_r;
  assign push_desc.held = (fill_inc < k) ? fill_inc : k;

  assign wr.en   = accept;
  assign wr.addr = {wbank_r, fill_r[IDX_W-1:0]};
  assign wr.data = in_tdata;

  always_comb begin
    fill_nxt  = fill_r;
    wbank_nxt = wbank_r;
    if (push) begin
      fill_nxt  = '0;
      wbank_nxt = !wbank_r;
    end else if (accept) begin
      fill_nxt = fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      wbank_r <= 1'b0;
    end else begin
      fill_r  <= fill_nxt;
      wbank_r <= wbank_nxt;
    end
  end

endmodule

// ----- design/btc_queue.sv -----
// Two-entry queue of closed-block descriptors between front and back.
// Depends on btc_pkg.
module btc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  btc_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output btc_pkg::desc_t head,
  output logic [1:0]     count
);
  import btc_pkg::*;

  desc_t      ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_valid = (cnt_r != 2'd0);
  assign q_full  = (cnt_r == 2'd2);
  assign head    = ent_r[rptr_r];
  assign count   = cnt_r;

  always_comb begin
    wptr_nxt = push ? !wptr_r : wptr_r;
    rptr_nxt = pop ? !rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- design/btc_back.sv -----
// Back end: holds the two-bank block buffer, walks each closed block in
// output order and drives the result register. Depends on btc_pkg.
module btc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [btc_pkg::CNT_W-1:0]   k,
  input  logic [btc_pkg::PERM_W-1:0]  perm,
  input  logic                        decrypt,
  input  btc_pkg::wr_t                wr,
  input  logic                        q_valid,
  input  btc_pkg::desc_t              head,
  output logic                        pop,
  output btc_pkg::back_st_t           st,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] out_byte
  output logic                        out_tlast   // last_of_block
);
  import btc_pkg::*;

  logic [7:0]       buf_mem [2*MAX_BLOCK];

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             flush_r, flush_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic [7:0]       hold_b_r;
  logic             hold_pad_r, hold_pad_nxt;
  logic             out_v_r, out_v_nxt;
  logic [7:0]       out_b_r, out_b_nxt;
  logic             out_l_r, out_l_nxt;

  logic             out_free;
  logic             step;
  logic             fin;
  logic             last_idx;
  logic [IDX_W-1:0] p;
  logic             found;
  logic [IDX_W-1:0] inv;
  logic [IDX_W-1:0] src;
  logic             cand_v;
  logic             cand_pad;
  logic             load_hold;
  logic             push_out;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      buf_mem[wr.addr] <= wr.data;
    end
  end

  assign out_free  = !out_v_r || out_tready;
  assign step      = q_valid && !flush_r && out_free;
  assign fin       = flush_r && out_free;
  assign pop       = fin;
  assign last_idx  = ({1'b0, idx_r} == (k - CNT_W'(1)));
  assign p         = perm_entry(perm, idx_r);
  assign load_hold = step && cand_v;

  // Inverse entry: last j below k whose permutation entry names this position
  always_comb begin
    found = 1'b0;
    inv   = '0;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      if ((CNT_W'(j) < k) && (perm_entry(perm, IDX_W'(j)) == idx_r)) begin
        found = 1'b1;
        inv   = IDX_W'(j);
      end
    end
  end

  always_comb begin
    src = decrypt ? inv : p;
    if (decrypt) begin
      cand_v   = found && ({1'b0, inv} < head.held);
      cand_pad = 1'b0;
    end else begin
      cand_v   = 1'b1;
      cand_pad = !({1'b0, p} < head.held);
    end
  end

  // One beat is held back so the block's final beat can carry tlast
  always_comb begin
    idx_nxt      = idx_r;
    flush_nxt    = flush_r;
    hold_v_nxt   = hold_v_r;
    hold_pad_nxt = hold_pad_r;
    push_out     = 1'b0;
    out_l_nxt    = out_l_r;
    out_b_nxt    = out_b_r;
    if (step) begin
      idx_nxt   = last_idx ? '0 : idx_r + IDX_W'(1);
      flush_nxt = last_idx;
      if (cand_v) begin
        push_out     = hold_v_r;
        out_l_nxt    = 1'b0;
        hold_v_nxt   = 1'b1;
        hold_pad_nxt = cand_pad;
      end
    end else if (fin) begin
      flush_nxt  = 1'b0;
      hold_v_nxt = 1'b0;
      push_out   = hold_v_r;
      out_l_nxt  = 1'b1;
    end
    if (push_out) begin
      out_b_nxt = hold_pad_r ? PAD_BYTE : hold_b_r;
    end
    out_v_nxt = push_out ? 1'b1 : (out_tready ? 1'b0 : out_v_r);
  end

  // Registered buffer read into the held-back beat
  always_ff @(posedge clk) begin
    if (load_hold) begin
      hold_b_r <= buf_mem[{head.bank, src}];
    end
    hold_pad_r <= hold_pad_nxt;
    out_b_r    <= out_b_nxt;
    out_l_r    <= out_l_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      flush_r  <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      idx_r    <= idx_nxt;
      flush_r  <= flush_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tlast  = out_l_r;
  assign st.hold_v  = hold_v_r;
  assign st.flush   = flush_r;

endmodule

// ----- design/block_transposition_cipher.sv -----
// Top level of the block transposition cipher: configuration registers,
// front end, descriptor queue and back end. Depends on btc_pkg.
//
// Usage:
//   in_*  : one text byte per beat, in_tlast marks the final byte of the
//           text and closes a partial block.
//   out_* : permuted bytes; out_tlast is set on the last beat of a block.
//   cfg_* : register writes (0 block length, 1 permutation table,
//           2 decrypt mode), always ready; write only while idle.
// Throughput: one input beat per cycle while fewer than two closed blocks
//   wait; the bytes go to one of two buffer banks. For each block the back
//   end steps once per output position, plus a closing step that
//   releases the held-back final beat.
// Order: a closed block's descriptor is registered in the queue; each byte
//   then passes through the held-back beat into the output register.
// Reset: synchronous, active low; clears the fill count, the queue and the
//   output valid flag and loads the register reset values.
// Receiver stall: the output register holds its beat; the back end stops
//   walking, the queue fills and then in_tready drops.
module block_transposition_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] text_byte
  input  logic                          in_tlast,   // end_of_text
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] out_byte
  output logic                          out_tlast,  // last_of_block
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btc_pkg::CFG_DW-1:0]    cfg_data
);
  import btc_pkg::*;

  logic [LEN_W-1:0]  blen_r;
  logic [PERM_W-1:0] perm_r;
  logic              decrypt_r;
  logic [CNT_W-1:0]  k;

  logic       push;
  desc_t      push_desc;
  wr_t        wr;
  logic       wbank;
  logic       q_valid;
  logic       q_full;
  desc_t      head;
  logic [1:0] q_count;
  logic       pop;
  back_st_t   back_st;

  assign cfg_ready = 1'b1;
  assign k         = eff_len(blen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r    <= LEN_RESET;
      perm_r    <= PERM_RESET;
      decrypt_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_LEN: blen_r    <= cfg_data[LEN_W-1:0];
        REG_PERM:      perm_r    <= cfg_data[PERM_W-1:0];
        REG_DECRYPT:   decrypt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  btc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .k         (k),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc),
    .wr        (wr),
    .wbank     (wbank)
  );

  btc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .head      (head),
    .count     (q_count)
  );

  btc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .k          (k),
    .perm       (perm_r),
    .decrypt    (decrypt_r),
    .wr         (wr),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .st         (back_st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  // The bank being filled must never be the one the back end is reading
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (q_count == 2'd1) |-> (head.bank != wbank))
    else $error("front writes the bank under emission");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count != 2'd3)
    else $error("descriptor queue overflow");

  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> (!back_st.hold_v && !back_st.flush))
    else $error("back end holds a beat with no block queued");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
